### design/cbt_pkg.sv
// Shared constants, codes and types of the colour blob tracker.
package cbt_pkg;

	localparam int MAX_BLOBS   = 32;
	localparam int COORD_BITS  = 10;
	localparam int SUM_BITS    = 30;
	localparam int COUNT_BITS  = 20;
	localparam int MARGIN_BITS = 6;
	localparam int CFG_BITS    = 20;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		COL_YELLOW = 3'd0,
		COL_WHITE  = 3'd1,
		COL_GREEN  = 3'd2,
		COL_RED    = 3'd3,
		COL_BLUE   = 3'd4,
		COL_NONE   = 3'd5
	} colour_t;

	typedef enum logic [0:0] {
		REG_BOX_MARGIN = 1'b0,
		REG_MIN_PIXELS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic                  valid;
		colour_t               colour;
		logic [SUM_BITS-1:0]   sum_x;
		logic [SUM_BITS-1:0]   sum_y;
		logic [COUNT_BITS-1:0] count;
		logic [COORD_BITS-1:0] min_x;
		logic [COORD_BITS-1:0] max_x;
		logic [COORD_BITS-1:0] min_y;
		logic [COORD_BITS-1:0] max_y;
	} entry_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		colour_t               colour;
	} pix_t;

	typedef struct packed {
		logic px_en;
		logic alloc;
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

### design/colour_blob_tracker_core.sv
// Top level of the colour blob tracker: classifier, chain of blob cells, report path.
//
// Pixels are taken one per clock: a pixel is classified in the first cycle and in the
// next all blob cells test and absorb it in parallel, so a frame streams in at one
// beat per cycle. An end-of-frame beat stalls the input until the report is done: the
// cell chain shifts towards the head one cell per cycle while the head blob is too small,
// and each blob at the head whose count reaches min_pix_q goes through a bit-serial
// divider (one quotient bit per cycle) for both centroid coordinates and is then reported.
// Reports wait on report_stall; once no qualifying blob is left, the table and overflow
// flag are cleared.
module colour_blob_tracker_core import cbt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [0:0]             cfg_index,
	input  logic [CFG_BITS-1:0]    cfg_data,
	input  logic                   pixel_valid,
	output logic                   pixel_stall,
	input  logic                   command,
	input  logic [COORD_BITS-1:0]  x,
	input  logic [COORD_BITS-1:0]  y,
	input  logic [7:0]             red,
	input  logic [7:0]             green,
	input  logic [7:0]             blue,
	output logic                   report_valid,
	input  logic                   report_stall,
	output logic [2:0]             colour,
	output logic [COORD_BITS-1:0]  centre_x,
	output logic [COORD_BITS-1:0]  centre_y,
	output logic [COUNT_BITS-1:0]  pixel_count,
	output logic                   overflow,
	output logic                   last
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [MARGIN_BITS-1:0] margin_q;
	logic [COUNT_BITS-1:0]  min_pix_q;
	logic                   dropped_q;

	// Stage 1: classified pixel.
	logic    px_vld_s1, eof_s1;
	pix_t    pix_s1;
	colour_t col_in;
	logic    accept;

	entry_t entries [MAX_BLOBS];
	entry_t next_e  [MAX_BLOBS];
	logic [MAX_BLOBS-1:0] match, qual, valid_vec;
	cell_ctl_t ctl;

	logic                  div_start, busy_x, busy_y;
	logic [SUM_BITS-1:0]   quo_x, quo_y;
	colour_t               hd_colour_q;
	logic [COUNT_BITS-1:0] hd_count_q;
	logic                  hd_last_q;
	logic                  emit;
	logic                  report_valid_q;

	cbt_classify u_class (.red(red), .green(green), .blue(blue), .colour(col_in));

	assign pixel_stall = (state_q != ST_IDLE) || eof_s1;
	assign accept      = pixel_valid && !pixel_stall;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q  <= MARGIN_BITS'(5);
			min_pix_q <= COUNT_BITS'(10);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BOX_MARGIN: margin_q  <= cfg_data[MARGIN_BITS-1:0];
				REG_MIN_PIXELS: min_pix_q <= cfg_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Drop odd-parity and uncoloured pixels before the cells see them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_vld_s1 <= 1'b0;
			eof_s1    <= 1'b0;
		end else begin
			px_vld_s1 <= accept && !command && !(x[0] ^ y[0]) && (col_in != COL_NONE);
			eof_s1    <= accept && command;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1.x      <= x;
		pix_s1.y      <= y;
		pix_s1.colour <= col_in;
	end

	// Cell chain: data moves from cell i+1 to cell i on a shift.
	always_comb begin
		ctl.px_en = px_vld_s1;
		ctl.alloc = px_vld_s1 && (match == '0);
		ctl.shift = ((state_q == ST_SCAN) && !qual[0] && (qual != '0)) || emit;
		ctl.clear = (state_q == ST_SCAN) && (qual == '0);
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_BLOBS; gi++) begin : g_cell
			if (gi == MAX_BLOBS - 1) begin : g_tail
				assign next_e[gi] = '0;
			end else begin : g_mid
				assign next_e[gi] = entries[gi+1];
			end
			cbt_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.pix       (pix_s1),
				.margin    (margin_q),
				.prev_valid((gi == 0) ? 1'b1 : valid_vec[(gi == 0) ? 0 : gi-1]),
				.next_entry(next_e[gi]),
				.entry     (entries[gi]),
				.match     (match[gi])
			);
			assign valid_vec[gi] = entries[gi].valid;
			assign qual[gi]      = entries[gi].valid && (entries[gi].count >= min_pix_q);
		end
	endgenerate

	// Table full: the last cell is taken. Set the overflow flag on a dropped blob.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dropped_q <= 1'b0;
		end else if (ctl.clear) begin
			dropped_q <= 1'b0;
		end else if (ctl.alloc && valid_vec[MAX_BLOBS-1]) begin
			dropped_q <= 1'b1;
		end
	end

	// Report sequencer.
	assign div_start = (state_q == ST_SCAN) && qual[0];
	assign emit      = (state_q == ST_EMIT) && (!report_valid_q || !report_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (eof_s1) state_q <= ST_SCAN;
				ST_SCAN: begin
					if (qual[0])          state_q <= ST_DIV;
					else if (qual == '0)  state_q <= ST_IDLE;
				end
				ST_DIV:  if (!busy_x) state_q <= ST_EMIT;
				ST_EMIT: if (emit) state_q <= ST_SCAN;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the head blob's fields while its centroid is worked out.
	always_ff @(posedge clk) begin
		if (div_start) begin
			hd_colour_q <= entries[0].colour;
			hd_count_q  <= entries[0].count;
			hd_last_q   <= ((qual >> 1) == '0);
		end
	end

	cbt_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(entries[0].sum_x), .divisor(entries[0].count),
		.busy(busy_x), .quotient(quo_x)
	);

	cbt_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(entries[0].sum_y), .divisor(entries[0].count),
		.busy(busy_y), .quotient(quo_y)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_valid_q <= 1'b0;
		end else if (emit) begin
			report_valid_q <= 1'b1;
		end else if (!report_stall) begin
			report_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			colour      <= hd_colour_q;
			centre_x    <= quo_x[COORD_BITS-1:0];
			centre_y    <= quo_y[COORD_BITS-1:0];
			pixel_count <= hd_count_q;
			overflow    <= dropped_q;
			last        <= hd_last_q;
		end
	end

	assign report_valid = report_valid_q;

	// Valid cells always form an unbroken run from the head.
	a_valid_run: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec >> 1) & ~valid_vec) == '0)
		else $error("cell valid bits not contiguous");

	// Both dividers run in lock step.
	a_div_sync: assert property (@(posedge clk) disable iff (!arst_n)
		busy_x == busy_y)
		else $error("centroid dividers out of step");

	// A finished scan empties the table.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && qual == '0) |=> (valid_vec == '0 && !dropped_q))
		else $error("table not cleared after report");

	// No report leaves the block while the divider is still running.
	a_emit_div: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !busy_x)
		else $error("report emitted during division");
endmodule

### design/cbt_classify.sv
// Colour classifier: priority yellow, white, green, red, blue.
module cbt_classify import cbt_pkg::*; (
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output colour_t    colour
);
	logic [15:0] r100, g100, b100;
	logic        is_y, is_w, is_g, is_r, is_b;

	assign r100 = 16'(red) * 16'd100;
	assign g100 = 16'(green) * 16'd100;
	assign b100 = 16'(blue) * 16'd100;

	always_comb begin
		is_y = (9'(red) > 9'(green) + 9'd20) && (green > 8'd180) && (blue != 8'd0)
			&& (blue < 8'd100);
		is_w = (red >= 8'd253) && (green >= 8'd253) && (blue >= 8'd253);
		is_g = (green >= 8'd80) && (r100 >= 16'(green) * 16'd70)
			&& (r100 <= 16'(green) * 16'd85) && (b100 >= 16'(green) * 16'd50)
			&& (b100 <= 16'(green) * 16'd58);
		is_r = (9'(red) > 9'(blue) + 9'd80) && (9'(red) > 9'(green) + 9'd80)
			&& (red > 8'd100);
		is_b = (blue >= 8'd80) && (r100 >= 16'(blue) * 16'd80)
			&& (r100 <= 16'(blue) * 16'd97) && (g100 >= 16'(blue) * 16'd109)
			&& (g100 <= 16'(blue) * 16'd128);
		priority if (is_y) colour = COL_YELLOW;
		else if (is_w)     colour = COL_WHITE;
		else if (is_g)     colour = COL_GREEN;
		else if (is_r)     colour = COL_RED;
		else if (is_b)     colour = COL_BLUE;
		else               colour = COL_NONE;
	end
endmodule

### design/cbt_cell.sv
// One blob cell: holds an entry, tests and absorbs pixels, shifts towards the head.
module cbt_cell import cbt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cell_ctl_t              ctl,
	input  pix_t                   pix,
	input  logic [MARGIN_BITS-1:0] margin,
	input  logic                   prev_valid,
	input  entry_t                 next_entry,
	output entry_t                 entry,
	output logic                   match
);
	localparam int W = COORD_BITS + 1;
	entry_t e_q;
	logic   valid_q;
	logic   take_new;
	logic [W-1:0] xm, ym;

	assign xm = W'(pix.x) + W'(margin);
	assign ym = W'(pix.y) + W'(margin);
	assign take_new = ctl.alloc && !valid_q && prev_valid;
	assign match = valid_q && ctl.px_en && (e_q.colour == pix.colour)
		&& (W'(pix.x) < W'(e_q.max_x) + W'(margin)) && (xm > W'(e_q.min_x))
		&& (W'(pix.y) < W'(e_q.max_y) + W'(margin)) && (ym > W'(e_q.min_y));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= next_entry.valid;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			e_q <= next_entry;
		end else if (take_new) begin
			e_q.colour <= pix.colour;
			e_q.sum_x  <= SUM_BITS'(pix.x);
			e_q.sum_y  <= SUM_BITS'(pix.y);
			e_q.count  <= COUNT_BITS'(1);
			e_q.min_x  <= pix.x;
			e_q.max_x  <= pix.x;
			e_q.min_y  <= pix.y;
			e_q.max_y  <= pix.y;
		end else if (match) begin
			if (e_q.count != COUNT_MAX) begin
				e_q.sum_x <= e_q.sum_x + SUM_BITS'(pix.x);
				e_q.sum_y <= e_q.sum_y + SUM_BITS'(pix.y);
				e_q.count <= e_q.count + COUNT_BITS'(1);
			end
			if (pix.x > e_q.max_x)      e_q.max_x <= pix.x;
			else if (pix.x < e_q.min_x) e_q.min_x <= pix.x;
			if (pix.y > e_q.max_y)      e_q.max_y <= pix.y;
			else if (pix.y < e_q.min_y) e_q.min_y <= pix.y;
		end
	end

	always_comb begin
		entry       = e_q;
		entry.valid = valid_q;
	end
endmodule

### design/cbt_div.sv
// Restoring divider: one quotient bit per cycle.
module cbt_div import cbt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SUM_BITS-1:0]   dividend,
	input  logic [COUNT_BITS-1:0] divisor,
	output logic                  busy,
	output logic [SUM_BITS-1:0]   quotient
);
	localparam int CW = $clog2(SUM_BITS + 1);
	logic [CW-1:0]         cnt_q;
	logic [COUNT_BITS-1:0] rem_q, den_q;
	logic [SUM_BITS-1:0]   quo_q;
	logic [COUNT_BITS:0]   part, trial;

	assign part  = {rem_q, quo_q[SUM_BITS-1]};
	assign trial = part - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(SUM_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[COUNT_BITS]) begin
				rem_q <= trial[COUNT_BITS-1:0];
				quo_q <= {quo_q[SUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= part[COUNT_BITS-1:0];
				quo_q <= {quo_q[SUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;
endmodule
